@@ hdl/c2s_pkg.sv @@
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared types, widths, turn constants and the arctangent table for the
// cartesian to spherical angle converter.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

	// field widths of the words on the ports
	localparam int COORD_WIDTH = 24;
	localparam int ANGLE_BITS = 16;

	// default number of micro-rotations (the table holds 24)
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_TABLE_LEN = 24;

	// block normalization: largest magnitude lands just below 2^30
	localparam int NORM_MAG_BITS = 30;
	localparam int NORM_W = NORM_MAG_BITS + 1;
	localparam int SHIFT_W = $clog2(NORM_MAG_BITS + 1);
	localparam int LEN_W = $clog2(COORD_WIDTH + 1);

	// x^2 + z^2 and its integer square root
	localparam int SQ_W = 2 * NORM_MAG_BITS;
	localparam int SUM_W = SQ_W + 1;
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int ISQ_W = SUM_W + 2;

	// turn accumulator and rotation datapath (two guard bits for gain and wrap)
	localparam int TURN_W = 32;
	localparam int ROT_W = TURN_W + 2;

	localparam logic [TURN_W-1:0] TURN_QUARTER = {2'b01, {(TURN_W-2){1'b0}}};
	localparam logic [TURN_W-1:0] TURN_HALF = {2'b10, {(TURN_W-2){1'b0}}};
	localparam logic [TURN_W-1:0] TURN_3QUARTER = {2'b11, {(TURN_W-2){1'b0}}};

	// rotation lanes
	localparam int NUM_LANES = 2;
	localparam int LANE_POL = 0;
	localparam int LANE_AZI = 1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_coord;
		logic signed [COORD_WIDTH-1:0] y_coord;
		logic signed [COORD_WIDTH-1:0] z_coord;
	} c2s_in_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] polar_angle;
		logic [ANGLE_BITS-1:0] azimuth_angle;
		logic                  zero_vector;
	} c2s_out_t;

	// input classification, carried down the pipe for the axis cases
	typedef struct packed {
		logic zero_vec;
		logic x_zero;
		logic z_zero;
		logic x_neg;
		logic y_zero;
		logic y_neg;
		logic z_neg;
	} c2s_flags_t;

	// normalized vector plus flags
	typedef struct packed {
		c2s_flags_t                flags;
		logic signed [NORM_W-1:0]  xn;
		logic signed [NORM_W-1:0]  yn;
		logic signed [NORM_W-1:0]  zn;
	} c2s_norm_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [TURN_W-1:0] atan_turn(input int unsigned idx);
		logic [TURN_W-1:0] v;
		case (idx)
			0:       v = 32'h2000_0000;
			1:       v = 32'h12E4_051E;
			2:       v = 32'h09FB_385B;
			3:       v = 32'h0511_11D4;
			4:       v = 32'h028B_0D43;
			5:       v = 32'h0145_D7E1;
			6:       v = 32'h00A2_F61E;
			7:       v = 32'h0051_7C55;
			8:       v = 32'h0028_BE53;
			9:       v = 32'h0014_5F2F;
			10:      v = 32'h000A_2F98;
			11:      v = 32'h0005_17CC;
			12:      v = 32'h0002_8BE6;
			13:      v = 32'h0001_45F3;
			14:      v = 32'h0000_A2FA;
			15:      v = 32'h0000_517D;
			16:      v = 32'h0000_28BE;
			17:      v = 32'h0000_145F;
			18:      v = 32'h0000_0A30;
			19:      v = 32'h0000_0518;
			20:      v = 32'h0000_028C;
			21:      v = 32'h0000_0146;
			22:      v = 32'h0000_00A3;
			23:      v = 32'h0000_0051;
			default: v = '0;
		endcase
		return v;
	endfunction

	// sign-extend a normalized coordinate into the rotation width
	function automatic logic signed [ROT_W-1:0] norm_to_rot(input logic [NORM_W-1:0] v);
		return {{(ROT_W-NORM_W){v[NORM_W-1]}}, v};
	endfunction

endpackage

`default_nettype wire

@@ hdl/cartesian_to_spherical_angles_unit.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical_angles_unit
// Converts a 3-D vector into its polar angle atan2(z, x) in [0, 2pi) and its
// azimuth from +y, atan2(sqrt(x^2 + z^2), y) in [0, pi], both as fractions
// of a full turn. Normalization, pipelined square root, two-lane CORDIC.
//
//   channel  ports                  handshake
//   -------  ---------------------  -----------------------------------------
//   input    coords (x, y, z)       word taken at a clock edge with start high
//                                   and busy low
//   output   result (angles, flag)  done high for one cycle per word
//
// busy is always low: a new word can be taken in every cycle.
// Between the accepting edge and done lie the front stages, the 31-stage
// square root, the CORDIC set-up stage, the micro-rotation chain and the
// output register.
// arst_n clears every valid bit; data registers are not reset.
// The receiver cannot hold results off, so the pipe never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_spherical_angles_unit
	import c2s_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire c2s_in_t coords,
	output logic         done,
	output c2s_out_t     result
);

	logic                    front_valid;
	c2s_norm_t               front_word;
	logic [SUM_W-1:0]        front_sumsq;
	logic                    sqrt_valid;
	c2s_norm_t               sqrt_side;
	logic [ROOT_W-1:0]       sqrt_root;
	logic                    rot_valid;
	c2s_flags_t              rot_flags;
	logic signed [ROT_W-1:0] pol_acc;
	logic signed [ROT_W-1:0] azi_acc;

	logic [TURN_W-1:0] pol_turn;
	logic [TURN_W-1:0] azi_turn;
	c2s_out_t          result_c;
	logic              done_q;
	c2s_out_t          result_q;

	// round half up from a turn value to the output angle, wrapping at a full turn
	function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [TURN_W-1:0] t);
		logic [TURN_W-1:0] s;
		s = t + (TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS));
		return s[TURN_W-1 -: ANGLE_BITS];
	endfunction

	assign busy = 1'b0;

	c2s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.in_word   (coords),
		.out_valid (front_valid),
		.out_word  (front_word),
		.out_sumsq (front_sumsq)
	);

	c2s_isqrt u_isqrt (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (front_valid),
		.in_side     (front_word),
		.in_radicand (front_sumsq),
		.out_valid   (sqrt_valid),
		.out_side    (sqrt_side),
		.out_root    (sqrt_root)
	);

	c2s_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sqrt_valid),
		.in_side     (sqrt_side),
		.in_root     (sqrt_root),
		.out_valid   (rot_valid),
		.out_flags   (rot_flags),
		.out_pol_acc (pol_acc),
		.out_azi_acc (azi_acc)
	);

	// polar angle: axis cases bypass the rotation result
	always_comb begin
		if (rot_flags.x_zero && rot_flags.z_zero) begin
			pol_turn = '0;
		end else if (rot_flags.z_zero) begin
			pol_turn = rot_flags.x_neg ? TURN_HALF : '0;
		end else if (rot_flags.x_zero) begin
			pol_turn = rot_flags.z_neg ? TURN_3QUARTER : TURN_QUARTER;
		end else begin
			pol_turn = pol_acc[TURN_W-1:0];
		end
	end

	// azimuth: axis cases, otherwise residue clamped to [0, half turn]
	always_comb begin
		if (rot_flags.x_zero && rot_flags.z_zero) begin
			azi_turn = rot_flags.y_neg ? TURN_HALF : '0;
		end else if (rot_flags.y_zero) begin
			azi_turn = TURN_QUARTER;
		end else if (azi_acc[ROT_W-1]) begin
			azi_turn = '0;
		end else if (azi_acc > $signed({2'b00, TURN_HALF})) begin
			azi_turn = TURN_HALF;
		end else begin
			azi_turn = azi_acc[TURN_W-1:0];
		end
	end

	// result word, zero vector forces both angles to zero
	always_comb begin
		if (rot_flags.zero_vec) begin
			result_c.polar_angle = '0;
			result_c.azimuth_angle = '0;
			result_c.zero_vector = 1'b1;
		end else begin
			result_c.polar_angle = to_angle(pol_turn);
			result_c.azimuth_angle = to_angle(azi_turn);
			result_c.zero_vector = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rot_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_c;
	end

	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ hdl/c2s_front.sv @@
// ----------------------------------------------------------------------------
// c2s_front
// Input register, common power-of-two normalization of x, y, z, and the
// sum of squares x'^2 + z'^2 that feeds the square root. Five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_front
	import c2s_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire c2s_in_t          in_word,
	output logic                  out_valid,
	output c2s_norm_t             out_word,
	output logic [SUM_W-1:0]      out_sumsq
);

	// stage 1: input word
	logic    valid_s1;
	c2s_in_t in_s1;

	// stage 2: shift amount and flags
	logic               valid_s2;
	c2s_in_t            in_s2;
	logic [SHIFT_W-1:0] shamt_s2;
	c2s_flags_t         flags_s2;

	// stage 3: normalized vector
	logic      valid_s3;
	c2s_norm_t norm_s3;

	// stage 4: squares
	logic            valid_s4;
	c2s_norm_t       norm_s4;
	logic [SQ_W-1:0] sqx_s4;
	logic [SQ_W-1:0] sqz_s4;

	// stage 5: sum of squares
	logic             valid_s5;
	c2s_norm_t        norm_s5;
	logic [SUM_W-1:0] sum_s5;

	logic [COORD_WIDTH-1:0] ux, uy, uz;
	logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_z, mag_xy, mag_max;
	logic [LEN_W-1:0]       bit_len;
	c2s_flags_t             flags_c;
	logic signed [NORM_W-1:0] ext_x, ext_y, ext_z;
	logic signed [2*NORM_W-1:0] prod_x, prod_z;

	// magnitudes and their maximum
	assign ux = in_s1.x_coord;
	assign uy = in_s1.y_coord;
	assign uz = in_s1.z_coord;
	assign mag_x = ux[COORD_WIDTH-1] ? (~ux + 1'b1) : ux;
	assign mag_y = uy[COORD_WIDTH-1] ? (~uy + 1'b1) : uy;
	assign mag_z = uz[COORD_WIDTH-1] ? (~uz + 1'b1) : uz;
	assign mag_xy = (mag_y > mag_x) ? mag_y : mag_x;
	assign mag_max = (mag_z > mag_xy) ? mag_z : mag_xy;

	// bit length of the largest magnitude
	always_comb begin
		bit_len = '0;
		for (int i = 0; i < COORD_WIDTH; i++) begin
			if (mag_max[i]) begin
				bit_len = LEN_W'(i + 1);
			end
		end
	end

	// classification of the raw input
	always_comb begin
		flags_c.x_zero = (ux == '0);
		flags_c.z_zero = (uz == '0);
		flags_c.y_zero = (uy == '0);
		flags_c.x_neg = ux[COORD_WIDTH-1];
		flags_c.y_neg = uy[COORD_WIDTH-1];
		flags_c.z_neg = uz[COORD_WIDTH-1];
		flags_c.zero_vec = flags_c.x_zero & flags_c.y_zero & flags_c.z_zero;
	end

	// sign extension ahead of the normalizing shift
	assign ext_x = $signed({{(NORM_W-COORD_WIDTH){in_s2.x_coord[COORD_WIDTH-1]}},
		in_s2.x_coord});
	assign ext_y = $signed({{(NORM_W-COORD_WIDTH){in_s2.y_coord[COORD_WIDTH-1]}},
		in_s2.y_coord});
	assign ext_z = $signed({{(NORM_W-COORD_WIDTH){in_s2.z_coord[COORD_WIDTH-1]}},
		in_s2.z_coord});

	// squares of the normalized x and z
	assign prod_x = norm_s3.xn * norm_s3.xn;
	assign prod_z = norm_s3.zn * norm_s3.zn;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		in_s1 <= in_word;

		in_s2 <= in_s1;
		shamt_s2 <= SHIFT_W'(NORM_MAG_BITS) - SHIFT_W'(bit_len);
		flags_s2 <= flags_c;

		norm_s3.flags <= flags_s2;
		norm_s3.xn <= ext_x <<< shamt_s2;
		norm_s3.yn <= ext_y <<< shamt_s2;
		norm_s3.zn <= ext_z <<< shamt_s2;

		norm_s4 <= norm_s3;
		sqx_s4 <= prod_x[SQ_W-1:0];
		sqz_s4 <= prod_z[SQ_W-1:0];

		norm_s5 <= norm_s4;
		sum_s5 <= {1'b0, sqx_s4} + {1'b0, sqz_s4};
	end

	assign out_valid = valid_s5;
	assign out_word = norm_s5;
	assign out_sumsq = sum_s5;

endmodule

`default_nettype wire

@@ hdl/c2s_isqrt.sv @@
// ----------------------------------------------------------------------------
// c2s_isqrt
// Pipelined integer square root, one result bit per stage (restoring,
// digit by digit). The normalized vector rides along with each word.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_isqrt
	import c2s_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire c2s_norm_t         in_side,
	input  wire logic [SUM_W-1:0]  in_radicand,
	output logic                   out_valid,
	output c2s_norm_t              out_side,
	output logic [ROOT_W-1:0]      out_root
);

	logic              valid_s [ROOT_W];
	c2s_norm_t         side_s  [ROOT_W];
	logic [SUM_W-1:0]  rem_s   [ROOT_W];
	logic [ROOT_W-1:0] root_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
		localparam int J = ROOT_W - 1 - k;

		logic              v_in;
		c2s_norm_t         side_in;
		logic [SUM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [ISQ_W-1:0]  trial;
		logic [ISQ_W-1:0]  rem_ext;

		// stage input: ports for the first bit, previous stage otherwise
		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign side_in = in_side;
			assign rem_in = in_radicand;
			assign root_in = '0;
		end else begin : g_next
			assign v_in = valid_s[k-1];
			assign side_in = side_s[k-1];
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// (q + 2^J)^2 - q^2 = q * 2^(J+1) + 2^(2J)
		assign rem_ext = ISQ_W'(rem_in);
		assign trial = (ISQ_W'(root_in) << (J + 1)) + (ISQ_W'(1) << (2 * J));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_in;
			end
		end

		// try the bit, keep it when the remainder covers it
		always_ff @(posedge clk) begin
			side_s[k] <= side_in;
			if (rem_ext >= trial) begin
				rem_s[k] <= SUM_W'(rem_ext - trial);
				root_s[k] <= root_in | (ROOT_W'(1) << J);
			end else begin
				rem_s[k] <= rem_in;
				root_s[k] <= root_in;
			end
		end
	end

	assign out_valid = valid_s[ROOT_W-1];
	assign out_side = side_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1];

endmodule

`default_nettype wire

@@ hdl/c2s_cordic.sv @@
// ----------------------------------------------------------------------------
// c2s_cordic
// Two-lane unrolled CORDIC in vectoring mode: one lane for atan2(z, x),
// one for atan2(r, y). A set-up stage folds the vectors into the right
// half plane, then one register stage per micro-rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_cordic
	import c2s_pkg::*;
#(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire c2s_norm_t          in_side,
	input  wire logic [ROOT_W-1:0]  in_root,
	output logic                    out_valid,
	output c2s_flags_t              out_flags,
	output logic signed [ROT_W-1:0] out_pol_acc,
	output logic signed [ROT_W-1:0] out_azi_acc
);

	logic                    valid_s [STAGES+1];
	c2s_flags_t              flags_s [STAGES+1];
	logic signed [ROT_W-1:0] a_s     [STAGES+1][NUM_LANES];
	logic signed [ROT_W-1:0] b_s     [STAGES+1][NUM_LANES];
	logic signed [ROT_W-1:0] acc_s   [STAGES+1][NUM_LANES];

	logic signed [ROT_W-1:0] xr, yr, zr, rr;

	assign xr = norm_to_rot(in_side.xn);
	assign yr = norm_to_rot(in_side.yn);
	assign zr = norm_to_rot(in_side.zn);
	assign rr = $signed({{(ROT_W-ROOT_W){1'b0}}, in_root});

	// set-up stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		flags_s[0] <= in_side.flags;
		// polar lane: negative x is mirrored through the origin, start at a half turn
		if (in_side.flags.x_neg) begin
			a_s[0][LANE_POL] <= -xr;
			b_s[0][LANE_POL] <= -zr;
			acc_s[0][LANE_POL] <= $signed({2'b00, TURN_HALF});
		end else begin
			a_s[0][LANE_POL] <= xr;
			b_s[0][LANE_POL] <= zr;
			acc_s[0][LANE_POL] <= '0;
		end
		// azimuth lane: negative y is turned by a quarter
		if (in_side.flags.y_neg) begin
			a_s[0][LANE_AZI] <= rr;
			b_s[0][LANE_AZI] <= -yr;
			acc_s[0][LANE_AZI] <= $signed({2'b00, TURN_QUARTER});
		end else begin
			a_s[0][LANE_AZI] <= yr;
			b_s[0][LANE_AZI] <= rr;
			acc_s[0][LANE_AZI] <= '0;
		end
	end

	// micro-rotations
	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [ROT_W-1:0] ANG =
			$signed({{(ROT_W-TURN_W){1'b0}}, atan_turn(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		// drive b toward zero, direction from the sign of b
		always_ff @(posedge clk) begin
			flags_s[i+1] <= flags_s[i];
			for (int l = 0; l < NUM_LANES; l++) begin
				if (!b_s[i][l][ROT_W-1]) begin
					a_s[i+1][l] <= a_s[i][l] + (b_s[i][l] >>> i);
					b_s[i+1][l] <= b_s[i][l] - (a_s[i][l] >>> i);
					acc_s[i+1][l] <= acc_s[i][l] + ANG;
				end else begin
					a_s[i+1][l] <= a_s[i][l] - (b_s[i][l] >>> i);
					b_s[i+1][l] <= b_s[i][l] + (a_s[i][l] >>> i);
					acc_s[i+1][l] <= acc_s[i][l] - ANG;
				end
			end
		end
	end

	assign out_valid = valid_s[STAGES];
	assign out_flags = flags_s[STAGES];
	assign out_pol_acc = acc_s[STAGES][LANE_POL];
	assign out_azi_acc = acc_s[STAGES][LANE_AZI];

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cartesian to spherical angle converter. A short
// table of axis, extreme and near-axis vectors runs first, then random
// vectors of mixed magnitude. Words other than typed rows are predicted
// in-bench in 64-bit integers: normalization, integer root and vectoring
// micro-rotations. Each done word is compared field by field in order.
// ----------------------------------------------------------------------------

module tb;
	import c2s_pkg::*;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int NUM_DIR = 26;
	localparam int NUM_RANDOM = 1625;
	localparam int CALM_TAIL = 150;
	localparam int DRAIN_CYCLES = 80;

	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] C_ZERO = '0;
	localparam logic signed [COORD_WIDTH-1:0] C_ONE = 1;
	localparam logic signed [COORD_WIDTH-1:0] C_NEG1 = -1;

	// angle codes on the result port
	localparam logic [ANGLE_BITS-1:0] ANG_ZERO = '0;
	localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = 1 << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] ANG_HALF = 1 << (ANGLE_BITS - 1);
	localparam logic [ANGLE_BITS-1:0] ANG_3QUARTER = 3 << (ANGLE_BITS - 2);

	// turn values in units of 2^-32 turn
	localparam longint TURN32_QUARTER = 64'sh4000_0000;
	localparam longint TURN32_HALF = 64'sh8000_0000;
	localparam longint TURN32_3QUARTER = 64'shC000_0000;

	// micro-rotation angles atan(2^-i), 2^-32 turn units
	localparam logic [31:0] ATAN_STEP [24] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
		32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
		32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
		32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
	};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
		logic                          typed;
		logic [ANGLE_BITS-1:0]         pol;
		logic [ANGLE_BITS-1:0]         azi;
		logic                          zf;
	} dir_row_t;

	// directed vectors; typed rows carry their result, others go to the predictor
	localparam dir_row_t DIR_TABLE [NUM_DIR] = '{
		'{C_ZERO, C_ZERO, C_ZERO, 1'b1, ANG_ZERO, ANG_ZERO, 1'b1},
		'{C_ONE, C_ZERO, C_ZERO, 1'b1, ANG_ZERO, ANG_QUARTER, 1'b0},
		'{C_NEG1, C_ZERO, C_ZERO, 1'b1, ANG_HALF, ANG_QUARTER, 1'b0},
		'{C_ZERO, C_ZERO, C_ONE, 1'b1, ANG_QUARTER, ANG_QUARTER, 1'b0},
		'{C_ZERO, C_ZERO, C_NEG1, 1'b1, ANG_3QUARTER, ANG_QUARTER, 1'b0},
		'{C_ZERO, C_ONE, C_ZERO, 1'b1, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_ZERO, C_NEG1, C_ZERO, 1'b1, ANG_ZERO, ANG_HALF, 1'b0},
		'{C_MAX, C_ZERO, C_ZERO, 1'b1, ANG_ZERO, ANG_QUARTER, 1'b0},
		'{C_MIN, C_ZERO, C_ZERO, 1'b1, ANG_HALF, ANG_QUARTER, 1'b0},
		'{C_ZERO, C_ZERO, C_MAX, 1'b1, ANG_QUARTER, ANG_QUARTER, 1'b0},
		'{C_ZERO, C_ZERO, C_MIN, 1'b1, ANG_3QUARTER, ANG_QUARTER, 1'b0},
		'{C_ZERO, C_MAX, C_ZERO, 1'b1, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_ZERO, C_MIN, C_ZERO, 1'b1, ANG_ZERO, ANG_HALF, 1'b0},
		'{C_MAX, C_MAX, C_MAX, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_MIN, C_MIN, C_MIN, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_MIN, C_MAX, C_MIN, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_MAX, C_MIN, C_MIN, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_ONE, C_ONE, C_ONE, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_NEG1, C_NEG1, C_NEG1, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_ONE, C_MAX, C_ZERO, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_ZERO, C_MIN, C_ONE, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_NEG1, C_MAX, C_NEG1, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_MAX, C_ONE, C_NEG1, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_MIN, C_NEG1, C_ONE, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_ONE, C_NEG1, C_MIN, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0},
		'{C_MAX, C_ZERO, C_MIN, 1'b0, ANG_ZERO, ANG_ZERO, 1'b0}
	};

	logic     clk;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	c2s_in_t  coords = '0;
	logic     done;
	c2s_out_t result;

	c2s_out_t pending_angles [$];
	int       fail_count = 0;

	cartesian_to_spherical_angles_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.coords (coords),
		.done   (done),
		.result (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop
	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// floor of the square root, bit by bit
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned rem, root, bitv;
		rem = n;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// vectoring: drive b to zero, accumulate the angle of (a, b)
	function automatic longint rotate_to_axis(input longint a, input longint b,
			input longint acc);
		longint na, nb;
		for (int i = 0; i < STAGES && i < 24; i++) begin
			if (b >= 0) begin
				na = a + (b >>> i);
				nb = b - (a >>> i);
				acc += longint'(ATAN_STEP[i]);
			end else begin
				na = a - (b >>> i);
				nb = b + (a >>> i);
				acc -= longint'(ATAN_STEP[i]);
			end
			a = na;
			b = nb;
		end
		return acc;
	endfunction

	// round half up from 32-bit turn to port width
	function automatic logic [ANGLE_BITS-1:0] turn_to_angle(input longint unsigned t);
		longint unsigned s;
		s = (t + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
		return s[ANGLE_BITS-1:0];
	endfunction

	// expected angles for one vector
	function automatic c2s_out_t predict_angles(input c2s_in_t w);
		longint x, y, z, xn, yn, zn, m, r, acc, f;
		int n;
		longint unsigned pol, azi;
		c2s_out_t res;
		x = longint'($signed(w.x_coord));
		y = longint'($signed(w.y_coord));
		z = longint'($signed(w.z_coord));
		res = '0;
		if (x == 0 && y == 0 && z == 0) begin
			res.zero_vector = 1'b1;
			return res;
		end
		// common scaling so the largest magnitude is just below 2^30
		m = (x < 0) ? -x : x;
		if ((y < 0 ? -y : y) > m) m = (y < 0) ? -y : y;
		if ((z < 0 ? -z : z) > m) m = (z < 0) ? -z : z;
		n = 0;
		while (n < 40 && (m >>> n) != 0)
			n++;
		if (n < 30) begin
			f = 64'sd1 <<< (30 - n);
			xn = x * f;
			yn = y * f;
			zn = z * f;
		end else begin
			xn = x >>> (n - 30);
			yn = y >>> (n - 30);
			zn = z >>> (n - 30);
		end
		// polar angle, axes bypass the rotation
		if (x == 0 && z == 0) acc = 0;
		else if (z == 0) acc = (x > 0) ? 0 : TURN32_HALF;
		else if (x == 0) acc = (z > 0) ? TURN32_QUARTER : TURN32_3QUARTER;
		else if (x < 0) acc = rotate_to_axis(-xn, -zn, TURN32_HALF);
		else acc = rotate_to_axis(xn, zn, 0);
		pol = acc;
		pol &= 64'hFFFF_FFFF;
		// azimuth from +y, clamped to a half turn
		r = longint'(int_sqrt(xn * xn + zn * zn));
		if (x == 0 && z == 0) begin
			acc = (y > 0) ? 0 : TURN32_HALF;
		end else if (y == 0) begin
			acc = TURN32_QUARTER;
		end else begin
			acc = (yn < 0) ? rotate_to_axis(r, -yn, TURN32_QUARTER)
				: rotate_to_axis(yn, r, 0);
			if (acc < 0) acc = 0;
			if (acc > TURN32_HALF) acc = TURN32_HALF;
		end
		azi = acc;
		res.polar_angle = turn_to_angle(pol);
		res.azimuth_angle = turn_to_angle(azi);
		return res;
	endfunction

	// one random coordinate of mixed magnitude
	function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
		logic signed [COORD_WIDTH-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5: begin
				v = $urandom;
				v = v >>> $urandom_range(0, COORD_WIDTH - 1);
			end
			6: begin
				v = $urandom_range(0, 8);
				v = v - 4;
			end
			7: begin
				case ($urandom_range(0, 4))
					0: v = C_MAX;
					1: v = C_MIN;
					2: v = C_ZERO;
					3: v = C_ONE;
					default: v = C_NEG1;
				endcase
			end
			8: v = C_ZERO;
			default: begin
				if ($urandom_range(0, 1)) v = C_MAX - $urandom_range(0, 15);
				else v = C_MIN + $urandom_range(0, 15);
			end
		endcase
		return v;
	endfunction

	// present one word and hold it until taken
	task automatic send_word(input c2s_in_t w, input c2s_out_t want);
		start <= 1'b1;
		coords <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_angles.push_back(want);
	endtask

	task automatic idle_for(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// hold off until every outstanding word has come back
	task automatic drain_pipe();
		start <= 1'b0;
		while (pending_angles.size() != 0)
			@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		c2s_out_t want;
		if (arst_n && done) begin
			if (pending_angles.size() == 0) begin
				$error("unexpected result word: polar_angle %0d azimuth_angle %0d zero_vector %0d",
					result.polar_angle, result.azimuth_angle, result.zero_vector);
				fail_count++;
			end else begin
				want = pending_angles.pop_front();
				if (result.polar_angle !== want.polar_angle) begin
					$error("polar_angle: expected %0d, got %0d",
						want.polar_angle, result.polar_angle);
					fail_count++;
				end
				if (result.azimuth_angle !== want.azimuth_angle) begin
					$error("azimuth_angle: expected %0d, got %0d",
						want.azimuth_angle, result.azimuth_angle);
					fail_count++;
				end
				if (result.zero_vector !== want.zero_vector) begin
					$error("zero_vector: expected %0d, got %0d",
						want.zero_vector, result.zero_vector);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		c2s_in_t  w;
		c2s_out_t want;
		dir_row_t row;
		int       idle_pct;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIR_TABLE[i]) begin
			row = DIR_TABLE[i];
			w.x_coord = row.x;
			w.y_coord = row.y;
			w.z_coord = row.z;
			if (row.typed) begin
				want.polar_angle = row.pol;
				want.azimuth_angle = row.azi;
				want.zero_vector = row.zf;
			end else begin
				want = predict_angles(w);
			end
			send_word(w, want);
			if ($urandom_range(0, 2) == 0)
				idle_for($urandom_range(1, 16));
		end
		drain_pipe();

		// random vectors
		idle_pct = 0;
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 20;
					default: idle_pct = 50;
				endcase
			end
			w.x_coord = rand_coord();
			w.y_coord = rand_coord();
			w.z_coord = rand_coord();
			case ($urandom_range(0, 99))
				0, 1, 2, 3: w = '0;
				4, 5, 6, 7, 8: begin
					w.x_coord = C_ZERO;
					w.z_coord = C_ZERO;
				end
				9, 10, 11, 12, 13: w.y_coord = C_ZERO;
				14, 15, 16, 17, 18: w.x_coord = C_ZERO;
				19, 20, 21, 22, 23: w.z_coord = C_ZERO;
				default: ;
			endcase
			send_word(w, predict_angles(w));
			if (i == NUM_RANDOM / 2)
				drain_pipe();
			else if (i < NUM_RANDOM - CALM_TAIL && $urandom_range(1, 100) <= idle_pct)
				idle_for($urandom_range(1, 16));
		end
		start <= 1'b0;

		// wait out the pipe
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/c2s_pkg.sv
hdl/c2s_front.sv
hdl/c2s_isqrt.sv
hdl/c2s_cordic.sv
hdl/cartesian_to_spherical_angles_unit.sv
verif/tb.sv
